// ----- hw/rtl/gmas_pkg.sv -----
`timescale 1ns / 1ps

package gmas_pkg;

    localparam int RING_DEPTH = 16;

    localparam int SMP_W  = 24;
    localparam int LEN_W  = 5;
    localparam int THR_W  = 24;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W  = SMP_W + $clog2(RING_DEPTH) + 1;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int EXT_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_RING_LENGTH     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_THRESHOLD  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DRIFT_THRESHOLD = 2'd2;

    localparam logic [LEN_W-1:0] RING_LENGTH_RESET = LEN_W'(16);

    typedef struct packed {
        logic take;
        logic read;
        logic accum;
        logic prep;
        logic div_step;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [EXT_W-1:0] l;
        l = EXT_W'(len);
        if (l == '0) begin
            l = EXT_W'(1);
        end else if (l > EXT_W'(RING_DEPTH)) begin
            l = EXT_W'(RING_DEPTH);
        end
        return CNT_W'(l);
    endfunction

endpackage

// ----- hw/rtl/gmas_if.sv -----
`timescale 1ns / 1ps

interface gmas_smp_if;
    logic                               valid;
    logic                               ready;
    logic signed [gmas_pkg::SMP_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gmas_rdg_if;
    logic                               valid;
    logic                               ready;
    logic signed [gmas_pkg::SMP_W-1:0]  reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

// ----- hw/rtl/gmas_ram.sv -----
`timescale 1ns / 1ps

module gmas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/gmas_ctrl.sv -----
`timescale 1ns / 1ps

module gmas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gmas_pkg::t_sts i_sts,
    output gmas_pkg::t_cmd o_cmd
);

    import gmas_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hw/rtl/gmas_dp.sv -----
`timescale 1ns / 1ps

module gmas_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gmas_pkg::t_cmd                    i_cmd,
    output gmas_pkg::t_sts                    o_sts,
    input  logic signed [gmas_pkg::SMP_W-1:0] i_sample,
    input  logic [gmas_pkg::LEN_W-1:0]        i_ring_length,
    input  logic [gmas_pkg::THR_W-1:0]        i_jump_threshold,
    input  logic [gmas_pkg::THR_W-1:0]        i_drift_threshold,
    input  logic                              i_restart,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [gmas_pkg::SMP_W-1:0] o_reading
);

    import gmas_pkg::*;

    logic signed [SMP_W-1:0] r_sample;
    logic [SLOT_W-1:0]       r_slot,  n_slot;
    logic [CNT_W-1:0]        r_fill,  n_fill;
    logic signed [SUM_W-1:0] r_sum,   n_sum;
    logic signed [SMP_W-1:0] r_avg,   n_avg;
    logic signed [SMP_W-1:0] r_held,  n_held;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_dq,    n_dq;
    logic [CNT_W-1:0]        r_rem,   n_rem;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out;

    logic [CNT_W-1:0]        len;
    logic [SMP_W-1:0]        ram_rdata;
    logic signed [SMP_W:0]   dev_s;
    logic signed [SMP_W:0]   dev_h;
    logic [SMP_W:0]          mag_s;
    logic [SMP_W:0]          mag_h;
    logic [CNT_W:0]          trial;
    logic [CNT_W:0]          slot_inc;
    logic [SUM_W-1:0]        quo;

    assign len = eff_len(i_ring_length);

    gmas_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accum),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // deviations against the average from before this item
    assign dev_s = {r_sample[SMP_W-1], r_sample} - {r_avg[SMP_W-1], r_avg};
    assign dev_h = {r_held[SMP_W-1], r_held} - {r_avg[SMP_W-1], r_avg};
    assign mag_s = dev_s[SMP_W] ? (SMP_W+1)'(-dev_s) : dev_s;
    assign mag_h = dev_h[SMP_W] ? (SMP_W+1)'(-dev_h) : dev_h;

    assign trial    = {r_rem, r_dq[SUM_W-1]};
    assign slot_inc = (CNT_W+1)'(r_slot) + (CNT_W+1)'(1);
    assign quo      = r_neg ? (~r_dq + SUM_W'(1)) : r_dq;

    always_comb begin
        n_slot = r_slot;
        n_fill = r_fill;
        n_sum  = r_sum;
        n_avg  = r_avg;
        n_held = r_held;
        n_dq   = r_dq;
        n_rem  = r_rem;
        if (i_restart) begin
            n_slot = '0;
            n_fill = '0;
            n_sum  = '0;
            n_avg  = '0;
        end else if (i_cmd.take) begin
            if ((CNT_W+1)'(r_slot) >= (CNT_W+1)'(len)) begin
                n_slot = '0;
            end
        end else if (i_cmd.read) begin
            if (r_fill == '0 || mag_s >= (SMP_W+1)'(i_jump_threshold)) begin
                n_held = r_sample;
            end else if (mag_h >= (SMP_W+1)'(i_drift_threshold)) begin
                n_held = r_avg;
            end
        end else if (i_cmd.accum) begin
            if (r_fill < len) begin
                n_fill = r_fill + CNT_W'(1);
                n_sum  = r_sum + SUM_W'(r_sample);
            end else begin
                n_sum = r_sum - SUM_W'($signed(ram_rdata)) + SUM_W'(r_sample);
            end
        end else if (i_cmd.prep) begin
            n_dq  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            n_rem = '0;
        end else if (i_cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            if (trial >= (CNT_W+1)'(r_fill)) begin
                n_rem = CNT_W'(trial - (CNT_W+1)'(r_fill));
                n_dq  = {r_dq[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = CNT_W'(trial);
                n_dq  = {r_dq[SUM_W-2:0], 1'b0};
            end
        end else if (i_cmd.finish) begin
            n_avg = $signed(quo[SMP_W-1:0]);
            if (slot_inc >= (CNT_W+1)'(len)) begin
                n_slot = '0;
            end else begin
                n_slot = SLOT_W'(slot_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_held      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
            r_fill <= n_fill;
            r_sum  <= n_sum;
            r_avg  <= n_avg;
            r_held <= n_held;
            if (i_cmd.prep) begin
                r_dcnt <= DCNT_W'(SUM_W - 1);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.prep) begin
            r_neg <= r_sum[SUM_W-1];
        end
        r_dq  <= n_dq;
        r_rem <= n_rem;
        if (i_cmd.emit) begin
            r_out <= r_held;
        end
    end

    assign o_sts.div_last = (r_dcnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_reading      = r_out;

endmodule

// ----- hw/rtl/governed_moving_average_smoother_unit.sv -----
`timescale 1ns / 1ps

// Moving-average meter smoother with a held reading. One sample item gives one
// reading item. Items are handled one at a time: after acceptance each goes
// through a ring read, a sum update, a divider setup, 29 steps of a bit-serial
// restoring divider of the 29-bit running sum by the fill count, a finish step
// and an output step before the reading is offered; no new sample is taken
// in between. The next sample is taken as soon as the reading sits in the
// output register, even if it has not been taken yet; a reading still waiting
// there holds the next one back. The sample ring is a 16-entry RAM with
// registered read. Writing ring_length (register 0) restarts the ring (fill
// count, sum and average cleared, held reading kept); the thresholds
// (registers 1 and 2) apply from the next sample on. Registers must only be
// written while no item is in flight.

module governed_moving_average_smoother_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gmas_smp_if.sink                             i_smp,
    gmas_rdg_if.source                           o_rdg,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gmas_pkg::ADDR_W-1:0]          paddr,
    input  logic [gmas_pkg::DATA_W-1:0]          pwdata,
    output logic [gmas_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    import gmas_pkg::*;

    logic [LEN_W-1:0]     r_ring_length;
    logic [THR_W-1:0]     r_jump_threshold;
    logic [THR_W-1:0]     r_drift_threshold;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 restart;
    t_cmd                 cmd;
    t_sts                 sts;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign restart = cfg_we && (cfg_idx == REG_RING_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length     <= RING_LENGTH_RESET;
            r_jump_threshold  <= '0;
            r_drift_threshold <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_RING_LENGTH:     r_ring_length     <= pwdata[LEN_W-1:0];
                REG_JUMP_THRESHOLD:  r_jump_threshold  <= pwdata[THR_W-1:0];
                REG_DRIFT_THRESHOLD: r_drift_threshold <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RING_LENGTH:     prdata = DATA_W'(r_ring_length);
            REG_JUMP_THRESHOLD:  prdata = DATA_W'(r_jump_threshold);
            REG_DRIFT_THRESHOLD: prdata = DATA_W'(r_drift_threshold);
            default:             prdata = '0;
        endcase
    end

    gmas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gmas_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_sample          (i_smp.sample),
        .i_ring_length     (r_ring_length),
        .i_jump_threshold  (r_jump_threshold),
        .i_drift_threshold (r_drift_threshold),
        .i_restart         (restart),
        .i_out_ready       (o_rdg.ready),
        .o_out_valid       (o_rdg.valid),
        .o_reading         (o_rdg.reading)
    );

    // one item in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("item accepted while another was in flight");

    // a reading only shows up at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rdg.valid) |-> $past(!i_smp.ready))
        else $error("reading offered without an item in work");

    // the datapath only gets the done command from its final step
    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> $past(cmd.div_step && sts.div_last))
        else $error("average finished before the divider ran out");

endmodule

// ----- test/gmas_reading_checker.sv -----
`timescale 1ns / 1ps

module gmas_reading_checker
    import gmas_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    gmas_smp_if                 i_smp,
    gmas_rdg_if                 i_rdg,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    output int                  o_mismatches,
    output int                  o_pending
);

    logic signed [SMP_W-1:0]  ring_mem [RING_DEPTH];
    logic [SLOT_W-1:0]        wr_slot;
    logic [CNT_W-1:0]         n_filled;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SMP_W-1:0]  mean_now;
    logic signed [SMP_W-1:0]  held_now;

    logic [LEN_W-1:0]         cfg_len;
    logic [THR_W-1:0]         cfg_jump;
    logic [THR_W-1:0]         cfg_drift;

    logic signed [SMP_W-1:0]  expected_readings [$];
    int                       mismatches;

    function automatic void restart_ring();
        wr_slot  = '0;
        n_filled = '0;
        acc_sum  = '0;
        mean_now = '0;
    endfunction

    function automatic logic signed [SMP_W-1:0] predict_reading(
        input logic signed [SMP_W-1:0] s
    );
        int     span;
        longint dev_new;
        longint dev_held;
        if (cfg_len == '0) begin
            span = 1;
        end else if (int'(cfg_len) > RING_DEPTH) begin
            span = RING_DEPTH;
        end else begin
            span = int'(cfg_len);
        end
        dev_new  = longint'(s) - longint'(mean_now);
        dev_held = longint'(held_now) - longint'(mean_now);
        if (dev_new < 0) begin
            dev_new = -dev_new;
        end
        if (dev_held < 0) begin
            dev_held = -dev_held;
        end

        // checks use the average from before this sample
        if (n_filled == '0 || dev_new >= longint'(cfg_jump)) begin
            held_now = s;
        end else if (dev_held >= longint'(cfg_drift)) begin
            held_now = mean_now;
        end

        if (int'(wr_slot) >= span) begin
            wr_slot = '0;
        end
        if (int'(n_filled) < span) begin
            n_filled = n_filled + 1'b1;
        end else begin
            acc_sum = acc_sum - ring_mem[wr_slot];
        end
        ring_mem[wr_slot] = s;
        acc_sum  = acc_sum + s;
        mean_now = SMP_W'(longint'(acc_sum) / longint'(n_filled));
        wr_slot  = (int'(wr_slot) + 1 >= span) ? '0 : wr_slot + 1'b1;
        return held_now;
    endfunction

    always @(posedge i_clk) begin
        logic [REG_IDX_W-1:0]    reg_idx;
        logic signed [SMP_W-1:0] want;
        reg_idx = i_paddr[ADDR_W-1:2];
        if (!i_rst_n) begin
            restart_ring();
            held_now   = '0;
            cfg_len    = RING_LENGTH_RESET;
            cfg_jump   = '0;
            cfg_drift  = '0;
            mismatches = 0;
            expected_readings.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (reg_idx)
                    REG_RING_LENGTH: begin
                        cfg_len = i_pwdata[LEN_W-1:0];
                        restart_ring();
                    end
                    REG_JUMP_THRESHOLD: begin
                        cfg_jump = i_pwdata[THR_W-1:0];
                    end
                    REG_DRIFT_THRESHOLD: begin
                        cfg_drift = i_pwdata[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_rdg.valid && i_rdg.ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: reading expected none, got %0d", $time, i_rdg.reading);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_rdg.reading !== want) begin
                        $display("%0t: reading expected %0d, got %0d",
                                 $time, want, i_rdg.reading);
                        mismatches++;
                    end
                end
            end

            if (i_smp.valid && i_smp.ready) begin
                expected_readings.push_back(predict_reading(i_smp.sample));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_readings.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import gmas_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 45;
    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] THR_MAX = DATA_W'({THR_W{1'b1}});

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 cycles = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    logic               hold_rdg = 1'b0;
    logic signed [SMP_W-1:0] level = '0;

    gmas_smp_if smp_ch ();
    gmas_rdg_if rdg_ch ();

    governed_moving_average_smoother_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_rdg   (rdg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gmas_reading_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (smp_ch),
        .i_rdg        (rdg_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rdg_ch.ready <= !hold_rdg && ($urandom_range(99) >= stall_pct);
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        do @(posedge i_clk); while (!smp_ch.ready);
    endtask

    task automatic wait_all_readings();
        smp_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            level = SMP_W'($urandom);
        end
        if (roll < 30) begin
            return SMP_W'($urandom);
        end
        if (roll < 36) begin
            return roll[0] ? SMP_MAX : SMP_MIN;
        end
        return level + SMP_W'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic logic [DATA_W-1:0] pick_threshold();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return $urandom;
        end
        if (roll < 30) begin
            return '0;
        end
        if (roll < 40) begin
            return THR_MAX;
        end
        return DATA_W'($urandom_range(3000));
    endfunction

    task automatic program_random_settings();
        int                roll;
        logic [LEN_W-1:0]  len;
        roll = $urandom_range(99);
        if (roll < 10) begin
            len = '0;
        end else if (roll < 20) begin
            len = '1;
        end else if (roll < 30) begin
            len = LEN_W'(RING_DEPTH);
        end else if (roll < 40) begin
            len = LEN_W'(1);
        end else begin
            len = LEN_W'($urandom_range(31));
        end
        if ($urandom_range(1)) begin
            apb_write(REG_RING_LENGTH, {(DATA_W-LEN_W)'($urandom), len});
        end
        if ($urandom_range(1)) begin
            apb_write(REG_JUMP_THRESHOLD, pick_threshold());
        end
        if ($urandom_range(1)) begin
            apb_write(REG_DRIFT_THRESHOLD, pick_threshold());
        end
    endtask

    initial begin
        int phase;
        int k;
        int mode;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero jump threshold, every sample becomes the reading
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(-1);
        send_sample(1);
        wait_all_readings();

        // largest jump threshold, zero drift threshold
        apb_write(REG_JUMP_THRESHOLD, THR_MAX);
        apb_write(REG_DRIFT_THRESHOLD, '0);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(100);
        wait_all_readings();

        // zero length counts as one
        apb_write(REG_RING_LENGTH, '0);
        send_sample(5);
        send_sample(-5);
        send_sample(1000);
        wait_all_readings();

        // length above ring depth, hysteresis band
        apb_write(REG_RING_LENGTH, DATA_W'(31));
        apb_write(REG_JUMP_THRESHOLD, DATA_W'(50));
        apb_write(REG_DRIFT_THRESHOLD, THR_MAX);
        send_sample(10);
        send_sample(20);
        send_sample(200);
        send_sample(30);
        wait_all_readings();

        // threshold write keeps the ring going
        apb_write(REG_JUMP_THRESHOLD, DATA_W'(1000));
        apb_write(REG_DRIFT_THRESHOLD, DATA_W'(5));
        send_sample(40);
        send_sample(-60);
        send_sample(2000);
        wait_all_readings();

        for (phase = 0; phase < 12; phase++) begin
            program_random_settings();
            mode      = phase % 4;
            idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 25 : 0;
            stall_pct <= (mode == 2) ? 73 : (mode == 3) ? 25 : 0;
            if (phase == 4) begin
                fork
                    begin
                        hold_rdg <= 1'b1;
                        repeat (250) @(posedge i_clk);
                        hold_rdg <= 1'b0;
                    end
                join_none
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 9 && k == 20) begin
                    wait_all_readings();
                end
                send_sample(pick_sample());
            end
            wait_all_readings();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gmas_pkg.sv
hw/rtl/gmas_if.sv
hw/rtl/gmas_ram.sv
hw/rtl/gmas_ctrl.sv
hw/rtl/gmas_dp.sv
hw/rtl/governed_moving_average_smoother_unit.sv
test/gmas_reading_checker.sv
test/tb.sv
